/* hdl/ubt_pkg.sv */
package ubt_pkg;

	// Table geometry and reset values
	localparam int          SLOTS_DEF = 16;
	localparam logic [15:0] EPH_RESET = 16'd48152;

	// Operation codes
	localparam logic [1:0] OP_BIND  = 2'd0;
	localparam logic [1:0] OP_CLOSE = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_AUTO   = 3'd1;
	localparam logic [2:0] ST_IN_USE    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic        bind_wr;   // fill the lowest free cell
		logic        clr;       // clear the cell named by clr_slot
		logic [3:0]  clr_slot;
		logic [15:0] key;       // port compared and written
		logic [31:0] owner;
	} cell_cmd_t;

	// Priority chain handed from one cell to the next
	typedef struct packed {
		logic hit_seen;   // a lower cell already matched the key
		logic free_seen;  // a lower cell is already free
	} cell_link_t;

endpackage

/* hdl/udp_port_bind_table_top.sv */
// Port binding table. Raise start with operation, port, owner_tag and slot
// while busy is low; the answer appears on status, slot_index and bound_port
// for exactly one cycle with done high and must be taken then, as it cannot
// be stalled. Close, find and bind with an explicit port pass through the
// EXEC state and then the done register. A bind with port 0 probes one
// candidate port per cycle against all slots at once and tries at most
// min(SLOTS + 1, 65536 - ephemeral_base) candidates. The next start may be
// accepted in the cycle that done is shown. Write cfg_wr_en only while idle.
module udp_port_bind_table_top #(
	parameter int SLOTS = ubt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] port,
	input  logic [31:0] owner_tag,
	input  logic [3:0]  slot,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  slot_index,
	output logic [15:0] bound_port,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import ubt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;

	logic [1:0]  state_q;
	logic [1:0]  op_q;
	logic [15:0] port_q;
	logic [31:0] owner_q;
	logic [3:0]  slot_q;
	logic [15:0] base_q;
	logic [15:0] cursor_q;
	logic [16:0] tries_q;
	logic        done_q;
	logic [2:0]  status_q;
	logic [3:0]  slot_index_q;
	logic [15:0] bound_port_q;

	logic [15:0] cand;
	logic [16:0] limit;
	cell_cmd_t   cmd;
	cell_link_t  link [SLOTS+1];
	logic [SLOTS-1:0] first_hit;
	logic [SLOTS-1:0] first_free;
	logic        any_hit;
	logic        any_free;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] free_idx;

	// Ephemeral candidate and attempt limit
	assign cand  = (cursor_q < base_q) ? base_q : cursor_q;
	assign limit = 17'h10000 - {1'b0, base_q};

	// Row of cells
	assign link[0] = '0;
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ubt_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.link_in    (link[i]),
			.link_out   (link[i+1]),
			.first_hit  (first_hit[i]),
			.first_free (first_free[i])
		);
	end
	assign any_hit  = link[SLOTS].hit_seen;
	assign any_free = link[SLOTS].free_seen;

	// One-hot to index
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (first_hit[i]) hit_idx = hit_idx | IW'(i);
			if (first_free[i]) free_idx = free_idx | IW'(i);
		end
	end

	// Command broadcast
	always_comb begin
		cmd.key      = (state_q == S_PROBE) ? cand : port_q;
		cmd.owner    = owner_q;
		cmd.clr_slot = slot_q;
		cmd.clr      = (state_q == S_EXEC) && (op_q == OP_CLOSE);
		cmd.bind_wr  = 1'b0;
		if (state_q == S_EXEC && op_q == OP_BIND && !any_hit) cmd.bind_wr = 1'b1;
		if (state_q == S_PROBE && !any_hit) cmd.bind_wr = 1'b1;
	end

	// Ephemeral base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= EPH_RESET;
		end else if (cfg_wr_en) begin
			base_q <= (cfg_wr_data == 16'd0) ? 16'd1 : cfg_wr_data;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= operation;
			port_q  <= port;
			owner_q <= owner_tag;
			slot_q  <= slot;
		end
	end

	// Sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= EPH_RESET;
			tries_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					tries_q <= '0;
					if (start) begin
						state_q <= (operation == OP_BIND && port == 16'd0) ? S_PROBE : S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PROBE: begin
					cursor_q <= (cand == 16'hFFFF) ? base_q : cand + 16'd1;
					tries_q  <= tries_q + 17'd1;
					if (!any_hit || (tries_q + 17'd1 == limit)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: begin
				status_q     <= ST_NOT_FOUND;
				slot_index_q <= 4'd0;
				bound_port_q <= 16'd0;
				case (op_q)
					OP_BIND: begin
						if (any_hit) begin
							status_q <= ST_IN_USE;
						end else if (any_free) begin
							status_q     <= ST_OK;
							slot_index_q <= 4'(free_idx);
							bound_port_q <= port_q;
						end else begin
							status_q <= ST_FULL;
						end
					end
					OP_CLOSE: begin
						status_q     <= ST_OK;
						slot_index_q <= slot_q;
					end
					OP_FIND: begin
						if (any_hit) begin
							status_q     <= ST_OK;
							slot_index_q <= 4'(hit_idx);
							bound_port_q <= port_q;
						end
					end
					default: begin
						status_q <= ST_NOT_FOUND;
					end
				endcase
			end
			S_PROBE: begin
				status_q     <= ST_NO_AUTO;
				slot_index_q <= 4'd0;
				bound_port_q <= 16'd0;
				if (!any_hit) begin
					if (any_free) begin
						status_q     <= ST_OK;
						slot_index_q <= 4'(free_idx);
						bound_port_q <= cand;
					end else begin
						status_q <= ST_FULL;
					end
				end
			end
			default: begin
				status_q     <= status_q;
				slot_index_q <= slot_index_q;
				bound_port_q <= bound_port_q;
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;
	assign bound_port = bound_port_q;

endmodule

/* hdl/ubt_cell.sv */
module ubt_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ubt_pkg::cell_cmd_t cmd,
	input  ubt_pkg::cell_link_t link_in,
	output ubt_pkg::cell_link_t link_out,
	output logic               first_hit,
	output logic               first_free
);
	import ubt_pkg::*;

	logic        used_q;
	logic [15:0] port_q;
	logic [31:0] owner_q;
	logic        hit;
	logic        clr_me;

	// Compare against the broadcast key and resolve priority along the row
	assign hit        = used_q && (port_q == cmd.key);
	assign first_hit  = hit && !link_in.hit_seen;
	assign first_free = !used_q && !link_in.free_seen;
	assign link_out.hit_seen  = link_in.hit_seen || hit;
	assign link_out.free_seen = link_in.free_seen || !used_q;
	assign clr_me = cmd.clr && (32'(cmd.clr_slot) == IDX);

	// Used flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.bind_wr && first_free) begin
			used_q <= 1'b1;
		end else if (clr_me) begin
			used_q <= 1'b0;
		end
	end

	// Binding payload
	always_ff @(posedge clk) begin
		if (cmd.bind_wr && first_free) begin
			port_q  <= cmd.key;
			owner_q <= cmd.owner;
		end else if (clr_me) begin
			port_q  <= '0;
			owner_q <= '0;
		end
	end

endmodule
